// ===== hw/rtl/bst_pkg.sv =====
// Shared codes and constants for the blower speed trim block.
package bst_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] FUNC_INHALE  = 2'd0;
  localparam logic [1:0] FUNC_EXHALE  = 2'd1;
  localparam logic [1:0] FUNC_CORRECT = 2'd2;
  localparam logic [1:0] FUNC_RELOAD  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET = 2'd0;
  localparam logic [1:0] CFG_BASE   = 2'd1;
  localparam logic [1:0] CFG_LEVEL  = 2'd2;

  localparam int SPEED_W = 16;
  localparam int PRESS_W = 16;
  localparam int FLOW_W  = 32;
  localparam int ERR_W   = PRESS_W + 1;

  localparam logic signed [PRESS_W-1:0] UNSET_MARK   = 16'sd10000;
  localparam logic signed [FLOW_W-1:0]  FLOW_IN_MIN  = 32'sd1000;
  localparam logic signed [FLOW_W-1:0]  FLOW_EX_MAX  = -32'sd1500;
  localparam logic [SPEED_W-1:0]        SPEED_FLOOR  = 16'd5000;
  localparam logic [SPEED_W-1:0]        SPEED_CLAMP  = 16'd25000;
  localparam logic [SPEED_W-1:0]        RELOAD_STEP  = 16'd2000;
  localparam logic [SPEED_W-1:0]        ORDER_GAP    = 16'd1000;
  localparam logic [SPEED_W-1:0]        RELIEF_BASE  = 16'd5000;
  localparam logic [2:0]                LEVEL_MAX    = 3'd4;
  localparam logic signed [ERR_W-1:0]   DEADBAND     = 17'sd10;
  localparam logic signed [PRESS_W-1:0] TARGET_RESET = 16'sd1000;

endpackage

// ===== hw/rtl/bst_trim.sv =====
// One speed trim step: gain times pressure error with deadband and saturation.
module bst_trim import bst_pkg::*; (
  input  logic [SPEED_W-1:0]      speed,
  input  logic signed [ERR_W-1:0] err,
  input  logic                    up,
  output logic [SPEED_W-1:0]      speed_out
);

  localparam int PROD_W = ERR_W + 5;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] err_x;
  logic signed [PROD_W-1:0] gain30;
  logic signed [PROD_W-1:0] gain20;
  logic signed [SUM_W-1:0]  speed_x;
  logic signed [SUM_W-1:0]  sum;

  assign err_x   = PROD_W'(err);
  assign gain30  = (err_x <<< 5) - (err_x <<< 1);
  assign gain20  = (err_x <<< 4) + (err_x <<< 2);
  assign speed_x = $signed({{(SUM_W-SPEED_W){1'b0}}, speed});

  always_comb begin
    if (err > 0) begin
      if (up) sum = speed_x + SUM_W'(gain30);
      else    sum = speed_x - SUM_W'(gain30);
    end else begin
      sum = speed_x - SUM_W'(gain20);
    end
    if (err > 0 && err < DEADBAND) begin
      speed_out = speed;
    end else if (sum < 0) begin
      speed_out = '0;
    end else if (sum > $signed(SUM_W'({SPEED_W{1'b1}}))) begin
      speed_out = '1;
    end else begin
      speed_out = sum[SPEED_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/blower_speed_trim_by_pressure.sv =====
// Top level of the blower speed trim block: trackers, speed state and stream ports.
//
// Holds four blower speeds (normal, inhale, exhale, relief) and two pressure
// trackers (lowest inhale pressure, highest exhale pressure, 10000 = unset).
// Each input transfer carries a kind on in_tuser: inhale sample, exhale sample,
// correct speeds or reload from configuration. Every input transfer yields
// exactly one result transfer with the four speeds after the item and a flag
// that marks an applied correction. The whole update is a single
// combinational pass from the state registers and the input payload into
// the state and the result register, so a new item is taken every cycle
// while the result side keeps up. The result register is
// refilled in the same cycle it is drained; in_tready drops only while a
// result waits and out_tready is low. Configuration writes are always
// accepted (cfg_ready is tied high) and take effect for the next item.
module blower_speed_trim_by_pressure import bst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] pressure, [47:16] flow
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] normal_speed, [31:16] inh_speed,
                                  // [47:32] exh_speed, [63:48] relief_speed
  output logic [0:0]  out_tuser,  // [0] corrected
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic signed [PRESS_W-1:0] target_r;
  logic [SPEED_W-1:0]        base_r;
  logic [3:0]                level_r;

  // speed and tracker state
  logic [SPEED_W-1:0]        normal_r, normal_nxt;
  logic [SPEED_W-1:0]        inhale_r, inhale_nxt;
  logic [SPEED_W-1:0]        exhale_r, exhale_nxt;
  logic [SPEED_W-1:0]        relief_r, relief_nxt;
  logic signed [PRESS_W-1:0] inh_min_r, inh_min_nxt;
  logic signed [PRESS_W-1:0] exh_max_r, exh_max_nxt;
  logic                      corr_nxt;

  // result register
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [0:0]  out_user_r;

  logic                      in_fire;
  logic [1:0]                func;
  logic signed [PRESS_W-1:0] press;
  logic signed [FLOW_W-1:0]  flow;

  assign func  = in_tuser;
  assign press = $signed(in_tdata[15:0]);
  assign flow  = $signed(in_tdata[47:16]);

  // take a new item whenever the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------- correction path ----------------
  logic signed [ERR_W-1:0] err_exh, err_inh, err_norm;
  logic [SPEED_W-1:0]      exh_trim, inh_trim, norm_trim;
  logic [SPEED_W-1:0]      exh_floor;
  logic [SPEED_W:0]        exh_plus;
  logic                    trackers_set;

  assign err_exh  = ERR_W'(exh_max_r) - ERR_W'(target_r);
  assign err_inh  = ERR_W'(target_r) - ERR_W'(inh_min_r);
  assign err_norm = ERR_W'(target_r) - ERR_W'(press);

  bst_trim u_trim_exh (.speed(exhale_r), .err(err_exh),  .up(1'b0), .speed_out(exh_trim));
  bst_trim u_trim_inh (.speed(inhale_r), .err(err_inh),  .up(1'b1), .speed_out(inh_trim));
  bst_trim u_trim_nrm (.speed(normal_r), .err(err_norm), .up(1'b1), .speed_out(norm_trim));

  assign trackers_set = (inh_min_r != UNSET_MARK) && (exh_max_r != UNSET_MARK);
  assign exh_floor    = (exh_trim < SPEED_FLOOR) ? SPEED_FLOOR : exh_trim;
  assign exh_plus     = {1'b0, exh_floor} + {1'b0, ORDER_GAP};

  // ---------------- reload path ----------------
  logic [SPEED_W:0]   base_plus;
  logic [SPEED_W-1:0] base_clamp;
  logic [2:0]         level_sat;
  logic [16:0]        relief_prod;

  assign base_plus  = {1'b0, base_r} + {1'b0, RELOAD_STEP};
  assign base_clamp = (base_r < SPEED_FLOOR) ? '0 :
                      (base_r > SPEED_CLAMP) ? SPEED_CLAMP : base_r;
  assign level_sat  = (level_r > 4'(LEVEL_MAX)) ? LEVEL_MAX : level_r[2:0];
  // quarter speed of at most 6250 times at most 4 stays below 2^15
  assign relief_prod = base_clamp[SPEED_W-1:2] * level_sat;

  always_comb begin
    normal_nxt  = normal_r;
    inhale_nxt  = inhale_r;
    exhale_nxt  = exhale_r;
    relief_nxt  = relief_r;
    inh_min_nxt = inh_min_r;
    exh_max_nxt = exh_max_r;
    corr_nxt    = 1'b0;
    case (func)
      FUNC_INHALE: begin
        if (inh_min_r == UNSET_MARK ||
            (flow >= FLOW_IN_MIN && press < inh_min_r)) inh_min_nxt = press;
      end
      FUNC_EXHALE: begin
        if (exh_max_r == UNSET_MARK ||
            (flow <= FLOW_EX_MAX && press > exh_max_r)) exh_max_nxt = press;
      end
      FUNC_CORRECT: begin
        if (trackers_set) begin
          corr_nxt    = 1'b1;
          exhale_nxt  = exh_floor;
          relief_nxt  = (relief_r < exh_floor) ? exh_floor - ORDER_GAP : relief_r;
          inhale_nxt  = (inh_trim >= exh_floor) ? inh_trim :
                        exh_plus[SPEED_W] ? '1 : exh_plus[SPEED_W-1:0];
          normal_nxt  = (norm_trim < exh_floor) ? exh_floor : norm_trim;
          inh_min_nxt = UNSET_MARK;
          exh_max_nxt = UNSET_MARK;
        end
      end
      FUNC_RELOAD: begin
        normal_nxt  = base_r;
        inhale_nxt  = base_plus[SPEED_W] ? '1 : base_plus[SPEED_W-1:0];
        exhale_nxt  = (base_r < RELOAD_STEP) ? '0 : base_r - RELOAD_STEP;
        relief_nxt  = relief_prod[SPEED_W-1:0] + RELIEF_BASE;
        inh_min_nxt = UNSET_MARK;
        exh_max_nxt = UNSET_MARK;
      end
      default: begin
      end
    endcase
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      base_r   <= '0;
      level_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET: target_r <= $signed(cfg_data);
        CFG_BASE:   base_r   <= cfg_data;
        CFG_LEVEL:  level_r  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // speed and tracker state advance on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r  <= '0;
      inhale_r  <= '0;
      exhale_r  <= '0;
      relief_r  <= '0;
      inh_min_r <= UNSET_MARK;
      exh_max_r <= UNSET_MARK;
    end else if (in_fire) begin
      normal_r  <= normal_nxt;
      inhale_r  <= inhale_nxt;
      exhale_r  <= exhale_nxt;
      relief_r  <= relief_nxt;
      inh_min_r <= inh_min_nxt;
      exh_max_r <= exh_max_nxt;
    end
  end

  // result register: load on input transfer, clear valid once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {relief_nxt, exhale_nxt, inhale_nxt, normal_nxt};
      out_user_r <= corr_nxt;
    end
  end

  // ---------------- assertions ----------------
  // an applied correction always leaves exhale at the floor or above, inhale and normal not below it
  a_corr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[0]) |->
      (out_data_r[47:32] >= SPEED_FLOOR && out_data_r[31:16] >= out_data_r[47:32] &&
       out_data_r[15:0] >= out_data_r[47:32]))
    else $error("correction result breaks speed ordering");

  // reload always leaves both trackers unset; an applied correction clears them as well
  a_reload_unset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && func == FUNC_RELOAD) |=>
      (inh_min_r == UNSET_MARK && exh_max_r == UNSET_MARK))
    else $error("trackers not cleared by reload");

  // every input transfer produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("input transfer without result");

endmodule
